// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl file positional_array_list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define PAL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define PAL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PAL_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define PAL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// shared types and constants of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int REQ_W          = 3;
    localparam int STATUS_W       = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_FIND   = 3'd2,
        REQ_GET    = 3'd3,
        REQ_SIZE   = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

endpackage

// ----- hdl/pal_req_if.sv -----
// ----------------------------------------------------------------------------
// pal_req_if
// request channel: valid/ready handshake with request payload
// ----------------------------------------------------------------------------
interface pal_req_if #(
    parameter int PW = 5,
    parameter int DW = 32
);
    logic                       valid;
    logic                       ready;
    logic [pal_pkg::REQ_W-1:0]  req_type;
    logic [PW-1:0]              position;
    logic signed [DW-1:0]       item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);
endinterface

// ----- hdl/pal_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pal_rsp_if
// result channel: valid/ready handshake with result payload
// ----------------------------------------------------------------------------
interface pal_rsp_if #(
    parameter int PW = 5,
    parameter int IW = 4,
    parameter int DW = 32
);
    logic                         valid;
    logic                         ready;
    logic [pal_pkg::STATUS_W-1:0] status;
    logic [IW-1:0]                found_index;
    logic signed [DW-1:0]         read_data;
    logic [PW-1:0]                entry_count;
    logic                         last;

    modport source (output valid, output status, output found_index, output read_data,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input found_index, input read_data,
                    input entry_count, input last, output ready);
endinterface

// ----- hdl/pal_ram.sv -----
// ----------------------------------------------------------------------------
// pal_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/positional_array_list.sv -----
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of signed words with insert, remove, find, get and size
// ----------------------------------------------------------------------------
// usage:
//   req carries one request per transaction (req_type, position, item_value);
//   rsp returns results (status, found_index, read_data, entry_count, last).
//   every request gives one result with last set, except find with several
//   matches, which gives one result per match in rising index order.
//   unknown request codes are dropped and give no result.
// sequencing (p = position), one request at a time:
//   insert shifts the entries from p upward by one, then writes the new word;
//   remove shifts the entries above p down by one; find scans every entry;
//   get reads one entry; size and rejected requests go straight to the result.
//   the list sits in one ram with one write and one registered read port;
//   shifts and scans move one entry per cycle through that port pair while find is not stalled.
// the output register holds a finished result, so the next request is taken
// while it waits; a stalled receiver stalls find between matches and holds
// every other request at its final result.
// reset clears the count and the control state; the ram needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_array_list #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pal_req_if.sink     req,
    pal_rsp_if.source   rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_FIND,
        S_GET,
        S_EMIT
    } state_t;

    // control state
    state_t         state_reg,   state_next;
    logic [PW-1:0]  count_reg,   count_next;
    logic [PW-1:0]  ptr_reg,     ptr_next;
    logic           wp_reg,      wp_next;
    logic           rv_reg,      rv_next;
    logic           held_reg,    held_next;
    logic           out_valid_reg, out_valid_next;

    // payload
    logic [PW-1:0]              pos_reg,        pos_next;
    logic [DATA_WIDTH-1:0]      val_reg,        val_next;
    logic [AW-1:0]              wa_reg,         wa_next;
    logic [AW-1:0]              cmp_idx_reg,    cmp_idx_next;
    logic [AW-1:0]              held_idx_reg,   held_idx_next;
    pal_pkg::status_t           res_status_reg, res_status_next;
    logic [AW-1:0]              res_idx_reg,    res_idx_next;
    logic [DATA_WIDTH-1:0]      res_data_reg,   res_data_next;
    pal_pkg::status_t           out_status_reg;
    logic [AW-1:0]              out_idx_reg;
    logic [DATA_WIDTH-1:0]      out_data_reg;
    logic [PW-1:0]              out_count_reg;
    logic                       out_last_reg;

    // output load
    logic                   out_load;
    pal_pkg::status_t       ld_status;
    logic [AW-1:0]          ld_idx;
    logic [DATA_WIDTH-1:0]  ld_data;
    logic                   ld_last;

    // ram ports
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [DATA_WIDTH-1:0]  mem_wd;
    logic                   mem_re;
    logic [AW-1:0]          mem_ra;
    logic [DATA_WIDTH-1:0]  mem_rd;

    logic           can_emit;
    logic           accept;
    logic           match;
    logic           stall;
    logic [PW-1:0]  ptr_dec;
    logic [PW-1:0]  ptr_inc;

    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign can_emit  = !out_valid_reg || rsp.ready;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign match     = (mem_rd == val_reg);
    // a second match with the previous one still unsent waits for the output
    assign stall     = rv_reg && match && held_reg && !can_emit;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wp_next         = wp_reg;
        rv_next         = rv_reg;
        held_next       = held_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        wa_next         = wa_reg;
        cmp_idx_next    = cmp_idx_reg;
        held_idx_next   = held_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_data_next   = res_data_reg;

        out_load  = 1'b0;
        ld_status = res_status_reg;
        ld_idx    = res_idx_reg;
        ld_data   = res_data_reg;
        ld_last   = 1'b1;

        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = mem_rd;
        mem_re = 1'b0;
        mem_ra = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next      = req.position;
                    val_next      = req.item_value;
                    res_idx_next  = '0;
                    res_data_next = '0;
                    wp_next       = 1'b0;
                    rv_next       = 1'b0;
                    held_next     = 1'b0;
                    case (pal_pkg::req_type_t'(req.req_type))
                        pal_pkg::REQ_INSERT:
                        begin
                            if (count_reg == PW'(DEPTH))
                            begin
                                res_status_next = pal_pkg::ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (req.position > count_reg)
                            begin
                                res_status_next = pal_pkg::ST_BADPOS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        pal_pkg::REQ_REMOVE:
                        begin
                            if (req.position >= count_reg)
                            begin
                                res_status_next = pal_pkg::ST_BADPOS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ptr_next   = req.position;
                                state_next = S_REM;
                            end
                        end
                        pal_pkg::REQ_FIND:
                        begin
                            ptr_next   = '0;
                            state_next = S_FIND;
                        end
                        pal_pkg::REQ_GET:
                        begin
                            if (req.position >= count_reg)
                            begin
                                res_status_next = pal_pkg::ST_BADPOS;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = req.position[AW-1:0];
                                state_next = S_GET;
                            end
                        end
                        pal_pkg::REQ_SIZE:
                        begin
                            res_status_next = pal_pkg::ST_OK;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // read entry i-1 now, write it to entry i next cycle
                if (wp_reg)
                begin
                    mem_we = 1'b1;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_re   = 1'b1;
                    mem_ra   = ptr_dec[AW-1:0];
                    wp_next  = 1'b1;
                    wa_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_dec;
                end
                else if (!wp_reg)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = pos_reg[AW-1:0];
                    mem_wd          = val_reg;
                    count_next      = count_reg + 1'b1;
                    res_status_next = pal_pkg::ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    wp_next = 1'b0;
                end
            end

            S_REM:
            begin
                if (wp_reg)
                begin
                    mem_we = 1'b1;
                end
                if (ptr_inc < count_reg)
                begin
                    mem_re   = 1'b1;
                    mem_ra   = ptr_inc[AW-1:0];
                    wp_next  = 1'b1;
                    wa_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_inc;
                end
                else if (!wp_reg)
                begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = pal_pkg::ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    wp_next = 1'b0;
                end
            end

            S_FIND:
            begin
                // the latest match is held back until it is known whether it is the last
                if (rv_reg && !stall && match)
                begin
                    if (held_reg)
                    begin
                        out_load  = 1'b1;
                        ld_status = pal_pkg::ST_OK;
                        ld_idx    = held_idx_reg;
                        ld_data   = '0;
                        ld_last   = 1'b0;
                    end
                    held_next     = 1'b1;
                    held_idx_next = cmp_idx_reg;
                end
                if (!stall)
                begin
                    if (ptr_reg < count_reg)
                    begin
                        mem_re       = 1'b1;
                        mem_ra       = ptr_reg[AW-1:0];
                        rv_next      = 1'b1;
                        cmp_idx_next = ptr_reg[AW-1:0];
                        ptr_next     = ptr_inc;
                    end
                    else
                    begin
                        rv_next = 1'b0;
                        if (!rv_reg)
                        begin
                            res_status_next = held_reg ? pal_pkg::ST_OK : pal_pkg::ST_NOTFOUND;
                            res_idx_next    = held_reg ? held_idx_reg : '0;
                            state_next      = S_EMIT;
                        end
                    end
                end
            end

            S_GET:
            begin
                res_data_next   = mem_rd;
                res_status_next = pal_pkg::ST_OK;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            wp_reg        <= 1'b0;
            rv_reg        <= 1'b0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            wp_reg        <= wp_next;
            rv_reg        <= rv_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        wa_reg         <= wa_next;
        cmp_idx_reg    <= cmp_idx_next;
        held_idx_reg   <= held_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_idx_reg    <= ld_idx;
            out_data_reg   <= ld_data;
            out_count_reg  <= count_reg;
            out_last_reg   <= ld_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_idx_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.last        = out_last_reg;

    `PAL_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= PW'(DEPTH))
    `PAL_ASSERT_ALWAYS(a_count_step, clk, rst_n, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1))
    `PAL_ASSERT_IMPL(a_write_state, clk, rst_n, mem_we, (state_reg == S_INS) || (state_reg == S_REM))
    `PAL_ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && ld_last, state_reg == S_IDLE)

endmodule
